/* hdl/ps2mt_pkg.sv */
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types and constants for the PS/2 mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

  // packet byte position
  typedef enum logic [1:0] {
    POS_HEAD = 2'd0,
    POS_DX   = 2'd1,
    POS_DY   = 2'd2
  } byte_pos_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_APPLIED  = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_OOB      = 2'd2
  } move_status_t;

  // configuration register indexes
  localparam logic CFG_X_LIMIT = 1'b0;
  localparam logic CFG_Y_LIMIT = 1'b1;

  localparam int LIMIT_W = 12;
  localparam int CUR_W   = 12;

  localparam logic [LIMIT_W-1:0] X_LIMIT_RST = 12'd1023;
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RST = 12'd767;

  // head byte bits
  localparam int HB_LEFT  = 0;
  localparam int HB_RIGHT = 1;
  localparam int HB_SYNC  = 3;
  localparam int HB_XSIGN = 4;
  localparam int HB_YSIGN = 5;
  localparam int HB_XOVF  = 6;
  localparam int HB_YOVF  = 7;

endpackage

/* hdl/ps2_mouse_packet_cursor_tracker_unit.sv */
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_unit
// Decodes 3-byte PS/2 mouse packets and tracks a bounded cursor position.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one mouse byte per word (tdata[7:0]). A head byte is taken only
//           when its sync bit (bit 3) is set; the next two bytes are X and Y.
//   out_* : one word per complete packet: buttons, cursor x/y and a status
//           (applied, dropped for overflow, dropped out of bounds).
//   cfg_* : write x_limit (index 0) and y_limit (index 1) while idle.
// The result word is registered and is valid the cycle after the third byte is taken.
// Throughput: one byte per cycle unless the output stalls; all packet logic
//   sits between the input handshake and the single output register.
// The output register is refilled in the same cycle it is drained, so a byte
//   is taken whenever the output is empty or being read. While the receiver
//   stalls with a result pending, in_tready stays low.
// Reset clears the packet position, stored bytes, the cursor to (0,0) and sets
//   the limits to 1023 and 767; no result is pending after reset.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_unit #(
  parameter int POS_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] data_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [0] left_button, [1] right_button, [13:2] cursor_x,
  //            [25:14] cursor_y, [27:26] move_status, [31:28] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [11:0] cfg_wdata
);

  localparam int CW = ((POS_BITS > ps2mt_pkg::LIMIT_W) ? POS_BITS : ps2mt_pkg::LIMIT_W) + 2;
  localparam logic signed [CW-1:0] POS_MAX = CW'((1 << POS_BITS) - 1);

  ps2mt_pkg::byte_pos_t          byte_pos_r, byte_pos_nxt;
  logic [7:0]                    head_r, head_nxt;
  logic [7:0]                    dx_r, dx_nxt;
  logic [POS_BITS-1:0]           pos_x_r, pos_x_nxt;
  logic [POS_BITS-1:0]           pos_y_r, pos_y_nxt;
  logic [1:0]                    buttons_r, buttons_nxt;
  logic [ps2mt_pkg::LIMIT_W-1:0] x_lim_r, y_lim_r;
  logic                          out_vld_r, out_vld_nxt;
  logic [31:0]                   out_data_r, out_data_nxt;

  logic                          in_acc;
  logic                          res_load;
  ps2mt_pkg::move_status_t       status;
  logic signed [8:0]             dx9, dy9;
  logic signed [CW-1:0]          nx, ny;
  logic [CW-1:0]                 cur_x_ext, cur_y_ext;
  logic                          oob;

  assign in_tready  = ~out_vld_r | out_tready;
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // 9-bit signed deltas and candidate position
  assign dx9 = $signed({head_r[ps2mt_pkg::HB_XSIGN], dx_r});
  assign dy9 = $signed({head_r[ps2mt_pkg::HB_YSIGN], in_tdata});
  assign nx  = $signed({{(CW-POS_BITS){1'b0}}, pos_x_r}) + CW'(dx9);
  assign ny  = $signed({{(CW-POS_BITS){1'b0}}, pos_y_r}) - CW'(dy9);
  assign oob = nx[CW-1] || nx > $signed({{(CW-ps2mt_pkg::LIMIT_W){1'b0}}, x_lim_r}) ||
               nx > POS_MAX ||
               ny[CW-1] || ny > $signed({{(CW-ps2mt_pkg::LIMIT_W){1'b0}}, y_lim_r}) ||
               ny > POS_MAX;

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    head_nxt     = head_r;
    dx_nxt       = dx_r;
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    buttons_nxt  = buttons_r;
    res_load     = 1'b0;
    status       = ps2mt_pkg::ST_APPLIED;
    if (in_acc) begin
      unique case (byte_pos_r)
        ps2mt_pkg::POS_HEAD: begin
          if (in_tdata[ps2mt_pkg::HB_SYNC]) begin
            head_nxt     = in_tdata;
            byte_pos_nxt = ps2mt_pkg::POS_DX;
          end
        end
        ps2mt_pkg::POS_DX: begin
          dx_nxt       = in_tdata;
          byte_pos_nxt = ps2mt_pkg::POS_DY;
        end
        default: begin
          byte_pos_nxt = ps2mt_pkg::POS_HEAD;
          res_load     = 1'b1;
          buttons_nxt  = head_r[1:0];
          if (head_r[ps2mt_pkg::HB_XOVF] | head_r[ps2mt_pkg::HB_YOVF]) begin
            status = ps2mt_pkg::ST_OVERFLOW;
          end else if (oob) begin
            status = ps2mt_pkg::ST_OOB;
          end else begin
            pos_x_nxt = nx[POS_BITS-1:0];
            pos_y_nxt = ny[POS_BITS-1:0];
          end
        end
      endcase
    end
  end

  assign cur_x_ext = {{(CW-POS_BITS){1'b0}}, pos_x_nxt};
  assign cur_y_ext = {{(CW-POS_BITS){1'b0}}, pos_y_nxt};

  always_comb begin
    out_vld_nxt  = out_vld_r & ~out_tready;
    out_data_nxt = out_data_r;
    if (res_load) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = {4'b0, status, cur_y_ext[ps2mt_pkg::CUR_W-1:0],
                      cur_x_ext[ps2mt_pkg::CUR_W-1:0], buttons_nxt[1], buttons_nxt[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= ps2mt_pkg::POS_HEAD;
      head_r     <= '0;
      dx_r       <= '0;
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      buttons_r  <= '0;
      x_lim_r    <= ps2mt_pkg::X_LIMIT_RST;
      y_lim_r    <= ps2mt_pkg::Y_LIMIT_RST;
      out_vld_r  <= 1'b0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      head_r     <= head_nxt;
      dx_r       <= dx_nxt;
      pos_x_r    <= pos_x_nxt;
      pos_y_r    <= pos_y_nxt;
      buttons_r  <= buttons_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          ps2mt_pkg::CFG_X_LIMIT: x_lim_r <= cfg_wdata;
          ps2mt_pkg::CFG_Y_LIMIT: y_lim_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // a byte without sync bit at the head position is dropped
  a_sync_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && byte_pos_r == ps2mt_pkg::POS_HEAD && !in_tdata[ps2mt_pkg::HB_SYNC]
    |=> byte_pos_r == ps2mt_pkg::POS_HEAD && !$rose(out_vld_r))
    else $error("unsynced head byte advanced the packet");

  // overflow packets leave the cursor where it was
  a_ovf_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && status == ps2mt_pkg::ST_OVERFLOW
    |=> $stable(pos_x_r) && $stable(pos_y_r))
    else $error("cursor moved on overflow packet");

  // the reported cursor is the tracked position
  a_out_pos: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_data_r[13:2] == cur_x_ext[ps2mt_pkg::CUR_W-1:0] ||
                 out_data_r[13:2] == $past(cur_x_ext[ps2mt_pkg::CUR_W-1:0]))
    else $error("result cursor x differs from tracked position");

  // results come only from the third byte of a packet
  a_third_byte: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> byte_pos_r != ps2mt_pkg::POS_HEAD && byte_pos_r != ps2mt_pkg::POS_DX)
    else $error("result issued before packet completed");

endmodule
